@@ src/gse_pkg.sv @@
// Package for the gray Sobel edge stream unit: sizes, register indexes, the
// item type shared by the front, queue and back, and the line-store word type.
// No dependencies.
package gse_pkg;

    // Widest row the line store holds.
    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int LS_AW        = $clog2(MAX_WIDTH);

    // Field widths fixed by the interface.
    localparam int COL_W  = 11;
    localparam int ROW_W  = 12;
    localparam int FW_W   = 12;
    localparam int FH_W   = 13;
    localparam int PIX_W  = 24;
    localparam int GRAY_W = 8;
    localparam int CFG_DW = 13;

    // Decoupling queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // Output position and its classification.
    typedef struct packed {
        logic             out_valid;
        logic             interior;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_pos;

    // One classified pixel on its way from the front to the back.
    typedef struct packed {
        logic [LS_AW-1:0]  addr;
        logic [GRAY_W-1:0] gray;
        t_pos              pos;
    } t_item;

    // One line-store word: line0 is the older of the two rows.
    typedef struct packed {
        logic [GRAY_W-1:0] line1;
        logic [GRAY_W-1:0] line0;
    } t_line_pair;

endpackage

@@ src/gse_front.sv @@
// Front part: configuration registers, gray conversion, raster position
// counters and output position classification for every accepted word.
// Depends on gse_pkg.
module gse_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [gse_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                  i_pix_valid,
    input  logic [gse_pkg::PIX_W-1:0] i_pixel_bgr,
    input  logic                  i_frame_start,
    input  logic                  i_full,
    output logic                  o_push,
    output gse_pkg::t_item        o_item
);
    import gse_pkg::*;

    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    logic [FW_W-1:0]  width;
    logic [FH_W-1:0]  height;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [FW_W-1:0]  col_inc;
    logic [FH_W-1:0]  row_inc;
    logic [15:0]      gray_sum;
    logic [COL_W-1:0] ocol_mid;
    logic [ROW_W-1:0] orow_mid;
    t_pos             pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_W'(640);
            r_frame_height <= FH_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Sizes are saturated to their legal ranges where they are used.
    always_comb begin
        if (r_frame_width < FW_W'(3))              width = FW_W'(3);
        else if (r_frame_width > FW_W'(MAX_WIDTH)) width = FW_W'(MAX_WIDTH);
        else                                       width = r_frame_width;
        if (r_frame_height < FH_W'(3))                 height = FH_W'(3);
        else if (r_frame_height > FH_W'(HEIGHT_LIMIT)) height = FH_W'(HEIGHT_LIMIT);
        else                                           height = r_frame_height;
    end

    assign o_push  = i_pix_valid && !i_full;
    assign cur_col = i_frame_start ? '0 : r_col;
    assign cur_row = i_frame_start ? '0 : r_row;

    assign gray_sum = 16'(16'd54 * {8'd0, i_pixel_bgr[23:16]})
                    + 16'(16'd183 * {8'd0, i_pixel_bgr[15:8]})
                    + 16'(16'd19 * {8'd0, i_pixel_bgr[7:0]})
                    + 16'd128;

    assign ocol_mid = cur_col - COL_W'(1);
    assign orow_mid = cur_row - ROW_W'(1);

    // The output trails the input by one row and one column. In column 0 it
    // names the last column of the row two above, which is always border.
    always_comb begin
        pos = '0;
        if (cur_col == '0) begin
            if (cur_row >= ROW_W'(2)) begin
                pos.out_valid = 1'b1;
                pos.col       = COL_W'(width - FW_W'(1));
                pos.row       = cur_row - ROW_W'(2);
            end
        end else if (cur_row != '0) begin
            pos.out_valid = 1'b1;
            pos.col       = ocol_mid;
            pos.row       = orow_mid;
            pos.interior  = (ocol_mid != '0) && (orow_mid != '0)
                         && ({1'b0, ocol_mid} < width - FW_W'(1))
                         && ({1'b0, orow_mid} < height - FH_W'(1));
        end
    end

    assign o_item.addr = cur_col[LS_AW-1:0];
    assign o_item.gray = gray_sum[15:8];
    assign o_item.pos  = pos;

    assign col_inc = {1'b0, cur_col} + FW_W'(1);
    assign row_inc = {1'b0, cur_row} + FH_W'(1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (o_push) begin
            if (col_inc >= width) begin
                n_col = '0;
                n_row = (row_inc >= height) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                n_col = col_inc[COL_W-1:0];
                n_row = cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

@@ src/gse_queue.sv @@
// Short FIFO of classified words between the front and the back part.
// Depends on gse_pkg.
module gse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gse_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output gse_pkg::t_item o_item
);
    import gse_pkg::*;

    t_item             r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop)      n_count = r_count + QCNT_W'(1);
        else if (!i_push && i_pop) n_count = r_count - QCNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            r_count <= n_count;
        end
    end

endmodule

@@ src/gse_back.sv @@
// Back part: two-row line store, 3x3 gray window, Sobel magnitude and the
// output register. Stages: line-store read, window update, output.
// Depends on gse_pkg.
module gse_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  gse_pkg::t_item               i_q_item,
    output logic                         o_q_pop,
    input  logic                         i_res_stall,
    output logic                         o_res_valid,
    output logic                         o_out_valid,
    output logic [7:0]                   o_edge_value,
    output logic [gse_pkg::COL_W-1:0]    o_out_column,
    output logic [gse_pkg::ROW_W-1:0]    o_out_row
);
    import gse_pkg::*;

    t_line_pair r_mem [MAX_WIDTH];
    t_line_pair r_rd_data;

    // Read stage.
    logic       r_b_valid;
    t_item      r_b_item;
    // Last line-store write, forwarded to a read issued in the same cycle.
    logic       r_lw_valid;
    logic [LS_AW-1:0] r_lw_addr;
    t_line_pair r_lw_data;
    // Window stage.
    logic       r_c_valid;
    t_pos       r_c_pos;
    logic [2:0][2:0][GRAY_W-1:0] r_win;
    // Output stage.
    logic       r_o_valid;
    t_pos       r_o_pos;
    logic [7:0] r_o_edge;

    logic       o_fire, o_free, c_fire, c_free, b_fire, b_free;
    t_line_pair b_data;
    t_line_pair n_wr_data;

    logic signed [11:0] gx, gy;
    logic [10:0] abs_gx, abs_gy;
    logic [11:0] mag;
    logic [7:0]  edge_sat;

    assign o_fire  = r_o_valid && !i_res_stall;
    assign o_free  = !r_o_valid || o_fire;
    assign c_fire  = r_c_valid && o_free;
    assign c_free  = !r_c_valid || c_fire;
    assign b_fire  = r_b_valid && c_free;
    assign b_free  = !r_b_valid || b_fire;
    assign o_q_pop = i_q_valid && b_free;

    assign b_data = (r_lw_valid && r_lw_addr == r_b_item.addr) ? r_lw_data : r_rd_data;

    // The older row drops out; the new gray value becomes the newer row.
    assign n_wr_data.line0 = b_data.line1;
    assign n_wr_data.line1 = r_b_item.gray;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rd_data <= r_mem[i_q_item.addr];
        end
        if (b_fire) begin
            r_mem[r_b_item.addr] <= n_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_b_item <= i_q_item;
        if (b_fire) begin
            r_c_pos   <= r_b_item.pos;
            r_lw_addr <= r_b_item.addr;
            r_lw_data <= n_wr_data;
        end
        if (c_fire) begin
            r_o_pos  <= r_c_pos;
            r_o_edge <= (r_c_pos.out_valid && r_c_pos.interior) ? edge_sat : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_lw_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            if (b_free) r_b_valid <= i_q_valid;
            if (c_free) r_c_valid <= r_b_valid;
            if (o_free) r_o_valid <= r_c_valid;
            if (b_fire) begin
                r_lw_valid <= 1'b1;
                for (int k = 0; k < 3; k++) begin
                    r_win[k][0] <= r_win[k][1];
                    r_win[k][1] <= r_win[k][2];
                end
                r_win[0][2] <= b_data.line0;
                r_win[1][2] <= b_data.line1;
                r_win[2][2] <= r_b_item.gray;
            end
        end
    end

    // Sobel kernels over the window: row 0 is the top row, column 0 the left.
    always_comb begin
        gx = (12'(r_win[0][2]) + 12'({r_win[1][2], 1'b0}) + 12'(r_win[2][2]))
           - (12'(r_win[0][0]) + 12'({r_win[1][0], 1'b0}) + 12'(r_win[2][0]));
        gy = (12'(r_win[0][0]) + 12'({r_win[0][1], 1'b0}) + 12'(r_win[0][2]))
           - (12'(r_win[2][0]) + 12'({r_win[2][1], 1'b0}) + 12'(r_win[2][2]));
        abs_gx   = gx[11] ? 11'(-gx) : gx[10:0];
        abs_gy   = gy[11] ? 11'(-gy) : gy[10:0];
        mag      = {1'b0, abs_gx} + {1'b0, abs_gy};
        edge_sat = (mag > 12'd255) ? 8'd255 : mag[7:0];
    end

    assign o_res_valid  = r_o_valid;
    assign o_out_valid  = r_o_pos.out_valid;
    assign o_edge_value = r_o_edge;
    assign o_out_column = r_o_pos.col;
    assign o_out_row    = r_o_pos.row;

endmodule

@@ src/gray_sobel_edge_stream_unit.sv @@
// Gray Sobel edge stream unit: one result word per accepted pixel word.
// Throughput: one word per cycle while the result side does not stall, set by one
// line-store read and one line-store write per cycle in the back part; a 4-word queue decouples the sides.
// Reset (synchronous, active low) clears counters, queue, pipeline valids
// and the window, and loads frame_width 640 and frame_height 480.
module gray_sobel_edge_stream_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [gse_pkg::CFG_DW-1:0]   i_cfg_data,
    input  logic                         i_pix_valid,
    output logic                         o_pix_stall,
    input  logic [gse_pkg::PIX_W-1:0]    i_pixel_bgr,
    input  logic                         i_frame_start,
    output logic                         o_res_valid,
    input  logic                         i_res_stall,
    output logic                         o_out_valid,
    output logic [7:0]                   o_edge_value,
    output logic [gse_pkg::COL_W-1:0]    o_out_column,
    output logic [gse_pkg::ROW_W-1:0]    o_out_row
);
    import gse_pkg::*;

    logic  push, pop, q_valid, q_full;
    t_item f_item, q_item;

    assign o_pix_stall = q_full;

    gse_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pix_valid   (i_pix_valid),
        .i_pixel_bgr   (i_pixel_bgr),
        .i_frame_start (i_frame_start),
        .i_full        (q_full),
        .o_push        (push),
        .o_item        (f_item)
    );

    gse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_item  (q_item)
    );

    gse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (pop),
        .i_res_stall  (i_res_stall),
        .o_res_valid  (o_res_valid),
        .o_out_valid  (o_out_valid),
        .o_edge_value (o_edge_value),
        .o_out_column (o_out_column),
        .o_out_row    (o_out_row)
    );

endmodule

@@ src/gse_checker.sv @@
// Port-level checks for the gray Sobel edge stream unit, bound to the top.
// Depends on gse_pkg and gray_sobel_edge_stream_unit.
module gse_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_pix_valid,
    input logic                       o_pix_stall,
    input logic [gse_pkg::PIX_W-1:0]  i_pixel_bgr,
    input logic                       i_frame_start,
    input logic                       o_res_valid,
    input logic                       i_res_stall,
    input logic                       o_out_valid,
    input logic [7:0]                 o_edge_value,
    input logic [gse_pkg::COL_W-1:0]  o_out_column,
    input logic [gse_pkg::ROW_W-1:0]  o_out_row
);
    import gse_pkg::*;

    // No result may be offered in the cycle after a reset.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_res_valid)
        else $error("result offered right after reset");

    // A stalled pixel word stays offered and unchanged.
    a_pix_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && o_pix_stall |=> i_pix_valid
            && $stable({i_pixel_bgr, i_frame_start}))
        else $error("stalled pixel word changed");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid
            && $stable({o_out_valid, o_edge_value, o_out_column, o_out_row}))
        else $error("stalled result word changed");

    // A position that is not yet real carries all-zero fields.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_out_valid |->
            o_edge_value == 8'd0 && o_out_column == '0 && o_out_row == '0)
        else $error("nonzero fields on a not-yet-valid position");

    // The first row and the first column are border.
    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_out_column == '0 || o_out_row == '0) |->
            o_edge_value == 8'd0)
        else $error("edge value on the top or left border");

endmodule

bind gray_sobel_edge_stream_unit gse_checker u_gse_checker (.*);

@@ sim/sobel_stream_checker.sv @@
// Checker for the gray Sobel edge stream unit: watches the pixel, result and
// register ports, predicts each result word and compares it field by field.
// Depends on gse_pkg for the port widths and register indexes.
module sobel_stream_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [gse_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        i_pix_valid,
    input  logic                        i_pix_stall,
    input  logic [gse_pkg::PIX_W-1:0]   i_pixel_bgr,
    input  logic                        i_frame_start,
    input  logic                        i_res_valid,
    input  logic                        i_res_stall,
    input  logic                        i_out_valid,
    input  logic [7:0]                  i_edge_value,
    input  logic [gse_pkg::COL_W-1:0]   i_out_column,
    input  logic [gse_pkg::ROW_W-1:0]   i_out_row,
    output int                          o_fail_count,
    output int                          o_pending
);
    import gse_pkg::*;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int MIN_SIZE     = 3;
    localparam int MAG_MAX      = 255;

    typedef struct packed {
        logic             out_valid;
        logic [7:0]       magnitude;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } t_edge_word;

    logic [FW_W-1:0]   frame_width_q;
    logic [FH_W-1:0]   frame_height_q;
    logic [GRAY_W-1:0] older_row [MAX_WIDTH];
    logic [GRAY_W-1:0] newer_row [MAX_WIDTH];
    int                win [3][3];
    int                col_pos;
    int                row_pos;
    t_edge_word        expected_edges [$];
    int                mismatches = 0;

    function automatic int clamp_size(input int value, input int lo, input int hi);
        if (value < lo) return lo;
        if (value > hi) return hi;
        return value;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Advances the gray window and line store by one pixel word and returns
    // the result word that this pixel releases.
    task automatic predict_edge_word(input logic [PIX_W-1:0] bgr, input logic starts_frame,
                                     output t_edge_word word);
        int width;
        int height;
        int gray;
        int c;
        int r;
        int ocol;
        int orow;
        int gx;
        int gy;
        int mag;
        width  = clamp_size(int'(frame_width_q), MIN_SIZE, MAX_WIDTH);
        height = clamp_size(int'(frame_height_q), MIN_SIZE, HEIGHT_LIMIT);
        gray   = (54 * int'(bgr[23:16]) + 183 * int'(bgr[15:8]) + 19 * int'(bgr[7:0])
                  + 128) >> 8;
        if (starts_frame) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos % MAX_WIDTH;
        r = row_pos;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = int'(older_row[c]);
        win[1][2] = int'(newer_row[c]);
        win[2][2] = gray;
        older_row[c] = newer_row[c];
        newer_row[c] = gray[GRAY_W-1:0];

        word = '0;
        if (c == 0) begin
            // Column 0 releases the last column of the row two above: border.
            if (r >= 2) begin
                word.out_valid = 1'b1;
                word.column    = COL_W'(width - 1);
                word.row       = ROW_W'(r - 2);
            end
        end else if (r >= 1) begin
            ocol = c - 1;
            orow = r - 1;
            word.out_valid = 1'b1;
            word.column    = COL_W'(ocol);
            word.row       = ROW_W'(orow);
            if (ocol != 0 && orow != 0 && ocol < width - 1 && orow < height - 1) begin
                gx = (win[0][2] + 2 * win[1][2] + win[2][2])
                   - (win[0][0] + 2 * win[1][0] + win[2][0]);
                gy = (win[0][0] + 2 * win[0][1] + win[0][2])
                   - (win[2][0] + 2 * win[2][1] + win[2][2]);
                mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
                word.magnitude = (mag > MAG_MAX) ? 8'(MAG_MAX) : mag[7:0];
            end
        end

        col_pos = c + 1;
        if (col_pos >= width) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= height) row_pos = 0;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_edge_word predicted;
        t_edge_word oldest;
        if (!i_rst_n) begin
            frame_width_q  = FW_W'(RESET_WIDTH);
            frame_height_q = FH_W'(RESET_HEIGHT);
            for (int a = 0; a < MAX_WIDTH; a++) begin
                older_row[a] = '0;
                newer_row[a] = '0;
            end
            for (int k = 0; k < 9; k++) win[k / 3][k % 3] = 0;
            col_pos = 0;
            row_pos = 0;
            expected_edges.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FRAME_WIDTH) frame_width_q = i_cfg_data[FW_W-1:0];
                else frame_height_q = i_cfg_data[FH_W-1:0];
            end
            if (i_pix_valid && !i_pix_stall) begin
                predict_edge_word(i_pixel_bgr, i_frame_start, predicted);
                expected_edges.push_back(predicted);
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_edges.size() == 0) begin
                    $error("result word with no pending expectation");
                    mismatches++;
                end else begin
                    oldest = expected_edges.pop_front();
                    check_field("out_valid", int'(oldest.out_valid), int'(i_out_valid));
                    check_field("edge_value", int'(oldest.magnitude), int'(i_edge_value));
                    check_field("out_column", int'(oldest.column), int'(i_out_column));
                    check_field("out_row", int'(oldest.row), int'(i_out_row));
                end
            end
        end
        o_pending    <= expected_edges.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ sim/tb_gray_sobel_edge_stream_unit.sv @@
// Testbench top for the gray Sobel edge stream unit: clock, reset, pixel and
// register stimulus, a randomly stalling result sink and the final verdict.
// Depends on gse_pkg, the unit itself and sobel_stream_checker.
module tb_gray_sobel_edge_stream_unit;
    import gse_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RESET_CYCLES  = 11;
    localparam int LONG_HOLD     = 100;
    localparam int RANDOM_ITEMS  = 260;
    localparam int QUIET_FROM    = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int MIN_SIZE      = 3;
    localparam int PRIME_WIDTH   = 48;

    typedef enum {PIX_NOISE, PIX_CONTRAST, PIX_FLAT} t_pix_style;
    typedef enum {FS_FRAMED, FS_FREE, FS_SCATTERED} t_fs_mode;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_we      = 1'b0;
    logic               cfg_index   = 1'b0;
    logic [CFG_DW-1:0]  cfg_data    = '0;
    logic               pix_valid   = 1'b0;
    logic               pix_stall;
    logic [PIX_W-1:0]   pixel_bgr   = '0;
    logic               frame_start = 1'b0;
    logic               res_valid;
    logic               res_stall   = 1'b0;
    logic               out_valid;
    logic [7:0]         edge_value;
    logic [COL_W-1:0]   out_column;
    logic [ROW_W-1:0]   out_row;
    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;

    logic               quiet       = 1'b0;
    logic               rx_idle     = 1'b1;
    logic               hold_req    = 1'b0;
    int                 tx_idle_pct = 25;

    logic [PIX_W-1:0] corner_px [8] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                                        24'h0000FF, 24'hAAAAAA, 24'h555555, 24'h80017F};

    gray_sobel_edge_stream_unit u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_pix_valid   (pix_valid),
        .o_pix_stall   (pix_stall),
        .i_pixel_bgr   (pixel_bgr),
        .i_frame_start (frame_start),
        .o_res_valid   (res_valid),
        .i_res_stall   (res_stall),
        .o_out_valid   (out_valid),
        .o_edge_value  (edge_value),
        .o_out_column  (out_column),
        .o_out_row     (out_row)
    );

    sobel_stream_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_pix_valid   (pix_valid),
        .i_pix_stall   (pix_stall),
        .i_pixel_bgr   (pixel_bgr),
        .i_frame_start (frame_start),
        .i_res_valid   (res_valid),
        .i_res_stall   (res_stall),
        .i_out_valid   (out_valid),
        .i_edge_value  (edge_value),
        .i_out_column  (out_column),
        .i_out_row     (out_row),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result sink: random stall bursts, plus one long hold on request so that
    // the unit fills up and has to stall its pixel input.
    initial begin : result_sink
        int   span;
        logic hold_done;
        logic stall_now;
        hold_done = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                stall_now = !quiet && rx_idle && ($urandom_range(0, 2) == 0);
                span      = stall_now ? $urandom_range(1, 17) : $urandom_range(1, 6);
                res_stall <= stall_now;
                repeat (span) @(posedge clk);
            end
        end
    end

    function automatic int clamp_size(input int value, input int lo, input int hi);
        if (value < lo) return lo;
        if (value > hi) return hi;
        return value;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input t_pix_style style,
                                                   input logic [PIX_W-1:0] base);
        case (style)
            PIX_CONTRAST: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
            PIX_FLAT:     return ($urandom_range(0, 15) == 0) ? PIX_W'($urandom()) : base;
            default:      return PIX_W'($urandom());
        endcase
    endfunction

    task automatic write_reg(input logic idx, input logic [CFG_DW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] bgr, input logic starts_frame);
        if (!quiet && tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        pix_valid   <= 1'b1;
        pixel_bgr   <= bgr;
        frame_start <= starts_frame;
        @(posedge clk);
        while (pix_stall) @(posedge clk);
    endtask

    // Registers may only change once every result word has come back.
    task automatic drain_results();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin : stimulus
        int                n;
        int                sel;
        int                which;
        int                frame_px;
        int                rand_items;
        logic [FW_W-1:0]   width_reg;
        logic [FH_W-1:0]   height_reg;
        logic [CFG_DW-1:0] wdata;
        logic [CFG_DW-1:0] hdata;
        logic [PIX_W-1:0]  base;
        logic              fs;
        t_pix_style        style;
        t_fs_mode          fs_mode;

        width_reg  = FW_W'(640);
        height_reg = FH_W'(480);
        rand_items = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner pixel values in row 0 at the reset size; none is valid yet.
        for (int k = 0; k < 8; k++) send_pixel(corner_px[k], k == 0 || k == 5);
        drain_results();

        // Two full rows write both line-store words of every column that the
        // later tests visit, and the height is written above its range.
        write_reg(CFG_FRAME_WIDTH, CFG_DW'(PRIME_WIDTH));
        write_reg(CFG_FRAME_HEIGHT, '1);
        cfg_we <= 1'b0;
        for (int k = 0; k < 2 * PRIME_WIDTH + 8; k++) send_pixel(PIX_W'($urandom()), k == 0);
        drain_results();

        // Sizes below range clamp to a 3x3 frame: a saturating edge first,
        // then a flat frame that follows by wrapping at the end of the frame.
        write_reg(CFG_FRAME_WIDTH, '0);
        write_reg(CFG_FRAME_HEIGHT, CFG_DW'(2));
        cfg_we <= 1'b0;
        for (int k = 0; k < 9; k++) send_pixel(k < 6 ? 24'hFFFFFF : 24'h000000, k == 0);
        for (int k = 0; k < 9; k++) send_pixel(24'h3C5A7E, 1'b0);
        drain_results();

        // Long hold on the result side while pixels keep coming.
        write_reg(CFG_FRAME_WIDTH, CFG_DW'(8));
        write_reg(CFG_FRAME_HEIGHT, CFG_DW'(6));
        cfg_we <= 1'b0;
        width_reg   = FW_W'(8);
        height_reg  = FH_W'(6);
        tx_idle_pct = 0;
        hold_req    <= 1'b1;
        for (int k = 0; k < 80; k++) send_pixel(PIX_W'($urandom()), k % 48 == 0);
        drain_results();

        while (rand_items < RANDOM_ITEMS) begin
            if (rand_items >= QUIET_FROM) quiet <= 1'b1;
            which = (rand_items == 0) ? 2 : $urandom_range(0, 2);

            sel = $urandom_range(0, 19);
            if (sel < 15) wdata = CFG_DW'($urandom_range(3, 9));
            else if (sel < 17) wdata = CFG_DW'($urandom_range(0, 2));
            else wdata = CFG_DW'($urandom_range(0, 8191));
            sel = $urandom_range(0, 19);
            if (sel < 15) hdata = CFG_DW'($urandom_range(3, 6));
            else if (sel < 17) hdata = CFG_DW'($urandom_range(0, 2));
            else hdata = CFG_DW'($urandom_range(0, 8191));

            if (which != 1) begin
                write_reg(CFG_FRAME_WIDTH, wdata);
                width_reg = wdata[FW_W-1:0];
            end
            if (which != 0) begin
                write_reg(CFG_FRAME_HEIGHT, hdata);
                height_reg = hdata[FH_W-1:0];
            end
            cfg_we <= 1'b0;

            frame_px = clamp_size(int'(width_reg), MIN_SIZE, MAX_WIDTH)
                     * clamp_size(int'(height_reg), MIN_SIZE, HEIGHT_LIMIT);
            // Big frames get only a few words so the run stays short.
            n = (frame_px <= 64) ? frame_px * $urandom_range(1, 3)
                                 : $urandom_range(8, PRIME_WIDTH);

            sel = $urandom_range(0, 9);
            fs_mode = (sel < 7) ? FS_FRAMED : (sel < 8) ? FS_FREE : FS_SCATTERED;
            // Big frames start at column 0 so they stay within the written columns.
            if (frame_px > 64) fs_mode = FS_FRAMED;
            sel = $urandom_range(0, 5);
            style = (sel < 4) ? PIX_NOISE : (sel < 5) ? PIX_CONTRAST : PIX_FLAT;
            base  = PIX_W'($urandom());
            sel = $urandom_range(0, 2);
            tx_idle_pct = (sel == 0) ? 0 : (sel == 1) ? 10 : 35;
            rx_idle <= ($urandom_range(0, 3) != 0);

            for (int k = 0; k < n; k++) begin
                case (fs_mode)
                    FS_FRAMED: fs = (k % frame_px == 0) && (k == 0 || $urandom_range(0, 1));
                    FS_FREE:   fs = 1'b0;
                    default:   fs = ($urandom_range(0, 7) == 0);
                endcase
                send_pixel(pick_pixel(style, base), fs);
            end
            rand_items += n;
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
